/* rtl/core/dkm_pkg.sv */
// shared constants, operation codes and memory control type for the dense key map
package dkm_pkg;

    localparam int KEY_W = 10;
    localparam int POS_W = KEY_W + 1;
    localparam int VALUE_W = 64;
    localparam int COUNT_W = 11;
    localparam int ENUM_W = 11;
    localparam int OP_W = 3;
    localparam int WORD_W = 64;
    localparam int BIT_W = 6;
    localparam int KEY_SPACE = 1 << KEY_W;

    localparam int DEF_KEY_COUNT = 1024;
    localparam int DEF_VALUE_WIDTH = 64;

    typedef enum logic [OP_W-1:0] {
        OP_SET        = 3'd0,
        OP_ERASE      = 3'd1,
        OP_LOOKUP     = 3'd2,
        OP_FIND_FIRST = 3'd3,
        OP_FIND_NEXT  = 3'd4,
        OP_CLEAR      = 3'd5
    } dkm_op_t;

    typedef struct packed {
        logic val_rd;
        logic val_wr;
        logic bm_rd;
        logic bm_wr;
    } dkm_mem_ctl_t;

endpackage

/* rtl/core/dkm_pri_enc.sv */
// shared find-first-set unit over one bitmap word, with a lower bound on the index
module dkm_pri_enc (
    input  logic [dkm_pkg::WORD_W-1:0] vec,
    input  logic [dkm_pkg::BIT_W-1:0]  lo,
    output logic                       hit,
    output logic [dkm_pkg::BIT_W-1:0]  idx
);

    logic [dkm_pkg::WORD_W-1:0] masked;
    logic [dkm_pkg::WORD_W-1:0] lowest;

    always_comb
    begin
        masked = vec & ({dkm_pkg::WORD_W{1'b1}} << lo);
        // isolate the lowest set bit
        lowest = masked & (~masked + 1'b1);
        hit = |masked;
        for (int b = 0; b < dkm_pkg::BIT_W; b++)
        begin
            idx[b] = 1'b0;
            for (int i = 0; i < dkm_pkg::WORD_W; i++)
            begin
                if (((i >> b) & 1) == 1)
                begin
                    idx[b] = idx[b] | lowest[i];
                end
            end
        end
    end

endmodule

/* rtl/core/dkm_mem.sv */
// value store and presence bitmap word memory, registered reads
module dkm_mem #(
    parameter int KEYS = dkm_pkg::DEF_KEY_COUNT,
    parameter int VALUE_WIDTH = dkm_pkg::DEF_VALUE_WIDTH,
    parameter int WORDS = (dkm_pkg::DEF_KEY_COUNT + dkm_pkg::WORD_W - 1) / dkm_pkg::WORD_W,
    parameter int AW = $clog2(KEYS),
    parameter int WA = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  logic                       clk,
    input  dkm_pkg::dkm_mem_ctl_t      ctl,
    input  logic [AW-1:0]              val_addr,
    input  logic [VALUE_WIDTH-1:0]     val_wdata,
    output logic [VALUE_WIDTH-1:0]     val_rdata,
    input  logic [WA-1:0]              bm_addr,
    input  logic [dkm_pkg::WORD_W-1:0] bm_wdata,
    output logic [dkm_pkg::WORD_W-1:0] bm_rdata
);

    logic [VALUE_WIDTH-1:0]     val_mem [KEYS];
    logic [dkm_pkg::WORD_W-1:0] bm_mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (ctl.val_wr)
        begin
            val_mem[val_addr] <= val_wdata;
        end
        if (ctl.val_rd)
        begin
            val_rdata <= val_mem[val_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.bm_wr)
        begin
            bm_mem[bm_addr] <= bm_wdata;
        end
        if (ctl.bm_rd)
        begin
            bm_rdata <= bm_mem[bm_addr];
        end
    end

endmodule

/* rtl/core/dense_key_map_with_presence_bitmap.sv */
// top level of the dense key map: sequencer, word valid and summary bits, key count
// set, erase and lookup read in S_ACCESS and finish in S_EVAL; clear, spare codes and finds
// with nothing to search finish in S_ACCESS; a find searches the start word in S_EVAL, then
// the summary bits in S_SCAN, both with the shared find-first-set unit, and a hit reads its
// value in S_VALUE before S_FINISH; busy drops in the done cycle, so a new item starts then
// reset (rst_n low, asynchronous) clears valid, summary bits and count at once; done never stalls
module dense_key_map_with_presence_bitmap #(
    parameter int KEY_COUNT = dkm_pkg::DEF_KEY_COUNT,
    parameter int VALUE_WIDTH = dkm_pkg::DEF_VALUE_WIDTH
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [dkm_pkg::OP_W-1:0]     operation,
    input  logic [dkm_pkg::KEY_W-1:0]    key,
    input  logic [dkm_pkg::VALUE_W-1:0]  value,
    input  logic [dkm_pkg::ENUM_W-1:0]   enumerated,
    output logic                         done,
    output logic                         found,
    output logic [dkm_pkg::KEY_W-1:0]    key_out,
    output logic [dkm_pkg::VALUE_W-1:0]  value_out,
    output logic [dkm_pkg::ENUM_W-1:0]   enumerated_out,
    output logic [dkm_pkg::COUNT_W-1:0]  entry_count
);

    // keys above the key port range can never be addressed
    localparam int KEYS = (KEY_COUNT < dkm_pkg::KEY_SPACE) ? KEY_COUNT : dkm_pkg::KEY_SPACE;
    localparam int WORDS = (KEYS + dkm_pkg::WORD_W - 1) / dkm_pkg::WORD_W;
    localparam int AW = $clog2(KEYS);
    localparam int WA = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam logic [dkm_pkg::POS_W-1:0] KEYS_POS = dkm_pkg::POS_W'(KEYS);
    localparam logic [dkm_pkg::POS_W-1:0] WORD_MASK = dkm_pkg::POS_W'(dkm_pkg::WORD_W - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_ACCESS,
        S_EVAL,
        S_SCAN,
        S_VALUE,
        S_FINISH
    } state_t;

    // sequencer state and item registers
    state_t                        state_reg, state_next;
    dkm_pkg::dkm_op_t              op_reg, op_next;
    logic [dkm_pkg::POS_W-1:0]     pos_reg, pos_next;      // key being worked on
    logic [VALUE_WIDTH-1:0]        val_reg, val_next;
    logic [dkm_pkg::ENUM_W-1:0]    enm_reg, enm_next;

    // map state kept in flops
    logic [dkm_pkg::COUNT_W-1:0]   count_reg, count_next;
    logic [WORDS-1:0]              wvalid_reg, wvalid_next; // word written since last clear
    logic [WORDS-1:0]              summ_reg, summ_next;     // word has any present key

    // registered result
    logic                          done_reg, done_next;
    logic                          found_reg, found_next;
    logic [dkm_pkg::KEY_W-1:0]     key_out_reg, key_out_next;
    logic [dkm_pkg::VALUE_W-1:0]   value_out_reg, value_out_next;
    logic [dkm_pkg::ENUM_W-1:0]    enm_out_reg, enm_out_next;
    logic [dkm_pkg::COUNT_W-1:0]   entry_reg, entry_next;

    // memory interface
    dkm_pkg::dkm_mem_ctl_t         mem_ctl;
    logic [VALUE_WIDTH-1:0]        val_rdata;
    logic [dkm_pkg::WORD_W-1:0]    bm_rdata;
    logic [dkm_pkg::WORD_W-1:0]    bm_wdata;

    // shared priority encoder
    logic [dkm_pkg::WORD_W-1:0]    pe_vec;
    logic [dkm_pkg::BIT_W-1:0]     pe_lo;
    logic                          pe_hit;
    logic [dkm_pkg::BIT_W-1:0]     pe_idx;

    // helpers
    logic [WA-1:0]                 widx;
    logic [dkm_pkg::BIT_W-1:0]     bit_sel;
    logic [dkm_pkg::WORD_W-1:0]    word;
    logic [dkm_pkg::WORD_W-1:0]    onehot;
    logic                          key_bit;
    logic                          in_range;
    logic [dkm_pkg::ENUM_W-1:0]    enm_sat;
    logic                          finish;
    logic                          fin_found;
    logic [dkm_pkg::KEY_W-1:0]     fin_key;
    logic [dkm_pkg::VALUE_W-1:0]   fin_value;

    assign widx     = pos_reg[dkm_pkg::BIT_W +: WA];
    assign bit_sel  = pos_reg[dkm_pkg::BIT_W-1:0];
    // a word not written since the last clear reads as empty
    assign word     = wvalid_reg[widx] ? bm_rdata : '0;
    assign onehot   = dkm_pkg::WORD_W'(1) << bit_sel;
    assign key_bit  = word[bit_sel];
    assign in_range = (pos_reg < KEYS_POS);
    assign enm_sat  = (enm_reg == '1) ? enm_reg : enm_reg + 1'b1;

    dkm_pri_enc u_pri_enc (
        .vec (pe_vec),
        .lo  (pe_lo),
        .hit (pe_hit),
        .idx (pe_idx)
    );

    dkm_mem #(
        .KEYS        (KEYS),
        .VALUE_WIDTH (VALUE_WIDTH),
        .WORDS       (WORDS),
        .AW          (AW),
        .WA          (WA)
    ) u_mem (
        .clk       (clk),
        .ctl       (mem_ctl),
        .val_addr  (pos_reg[AW-1:0]),
        .val_wdata (val_reg),
        .val_rdata (val_rdata),
        .bm_addr   (widx),
        .bm_wdata  (bm_wdata),
        .bm_rdata  (bm_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        pos_next       = pos_reg;
        val_next       = val_reg;
        enm_next       = enm_reg;
        count_next     = count_reg;
        wvalid_next    = wvalid_reg;
        summ_next      = summ_reg;
        done_next      = 1'b0;
        found_next     = found_reg;
        key_out_next   = key_out_reg;
        value_out_next = value_out_reg;
        enm_out_next   = enm_out_reg;
        entry_next     = entry_reg;
        mem_ctl        = '0;
        bm_wdata       = word | onehot;
        pe_vec         = word;
        pe_lo          = bit_sel;
        finish         = 1'b0;
        fin_found      = 1'b0;
        fin_key        = '0;
        fin_value      = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    op_next   = dkm_pkg::dkm_op_t'(operation);
                    val_next  = value[VALUE_WIDTH-1:0];
                    enm_next  = enumerated;
                    pos_next  = dkm_pkg::POS_W'(key);
                    case (dkm_pkg::dkm_op_t'(operation))
                        dkm_pkg::OP_FIND_FIRST: pos_next = '0;
                        dkm_pkg::OP_FIND_NEXT:  pos_next = dkm_pkg::POS_W'(key) + 1'b1;
                        default:                pos_next = dkm_pkg::POS_W'(key);
                    endcase
                    state_next = S_ACCESS;
                end
            end

            S_ACCESS:
            begin
                case (op_reg)
                    dkm_pkg::OP_CLEAR:
                    begin
                        wvalid_next = '0;
                        summ_next   = '0;
                        count_next  = '0;
                        finish      = 1'b1;
                    end
                    dkm_pkg::OP_SET, dkm_pkg::OP_ERASE, dkm_pkg::OP_LOOKUP:
                    begin
                        if (in_range)
                        begin
                            mem_ctl.bm_rd  = 1'b1;
                            mem_ctl.val_rd = 1'b1;
                            state_next     = S_EVAL;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    dkm_pkg::OP_FIND_FIRST, dkm_pkg::OP_FIND_NEXT:
                    begin
                        if (in_range && ((op_reg == dkm_pkg::OP_FIND_FIRST) ?
                                         (count_reg != '0) : (enm_reg < count_reg)))
                        begin
                            mem_ctl.bm_rd = 1'b1;
                            state_next    = S_EVAL;
                        end
                        else
                        begin
                            finish = 1'b1;
                        end
                    end
                    default:
                    begin
                        finish = 1'b1;
                    end
                endcase
            end

            S_EVAL:
            begin
                case (op_reg)
                    dkm_pkg::OP_LOOKUP:
                    begin
                        fin_found = key_bit;
                        fin_value = key_bit ? dkm_pkg::VALUE_W'(val_rdata) : '0;
                        finish    = 1'b1;
                    end
                    dkm_pkg::OP_SET:
                    begin
                        mem_ctl.bm_wr      = 1'b1;
                        mem_ctl.val_wr     = 1'b1;
                        bm_wdata           = word | onehot;
                        wvalid_next[widx]  = 1'b1;
                        summ_next[widx]    = 1'b1;
                        if (!key_bit)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        finish = 1'b1;
                    end
                    dkm_pkg::OP_ERASE:
                    begin
                        bm_wdata = word & ~onehot;
                        if (key_bit)
                        begin
                            mem_ctl.bm_wr     = 1'b1;
                            wvalid_next[widx] = 1'b1;
                            summ_next[widx]   = |(word & ~onehot);
                            count_next        = count_reg - 1'b1;
                        end
                        finish = 1'b1;
                    end
                    default:
                    begin
                        // find: search this word from the start bit up
                        pe_vec = word;
                        pe_lo  = bit_sel;
                        if (pe_hit)
                        begin
                            pos_next   = (pos_reg & ~WORD_MASK) | dkm_pkg::POS_W'(pe_idx);
                            state_next = S_VALUE;
                        end
                        else
                        begin
                            // first key of the following word
                            pos_next   = (pos_reg | WORD_MASK) + 1'b1;
                            state_next = S_SCAN;
                        end
                    end
                endcase
            end

            S_SCAN:
            begin
                // summary bits point at the next word holding a present key
                pe_vec = dkm_pkg::WORD_W'(summ_reg);
                pe_lo  = dkm_pkg::BIT_W'(pos_reg >> dkm_pkg::BIT_W);
                if (pe_hit)
                begin
                    pos_next   = dkm_pkg::POS_W'(pe_idx) << dkm_pkg::BIT_W;
                    state_next = S_ACCESS;
                end
                else
                begin
                    finish = 1'b1;
                end
            end

            S_VALUE:
            begin
                mem_ctl.val_rd = 1'b1;
                state_next     = S_FINISH;
            end

            S_FINISH:
            begin
                fin_found = 1'b1;
                fin_key   = pos_reg[dkm_pkg::KEY_W-1:0];
                fin_value = dkm_pkg::VALUE_W'(val_rdata);
                finish    = 1'b1;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (finish)
        begin
            state_next     = S_IDLE;
            done_next      = 1'b1;
            found_next     = fin_found;
            key_out_next   = fin_key;
            value_out_next = fin_value;
            enm_out_next   = (op_reg == dkm_pkg::OP_FIND_NEXT) ? enm_sat : '0;
            entry_next     = count_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= dkm_pkg::OP_SET;
            pos_reg       <= '0;
            val_reg       <= '0;
            enm_reg       <= '0;
            count_reg     <= '0;
            wvalid_reg    <= '0;
            summ_reg      <= '0;
            done_reg      <= 1'b0;
            found_reg     <= 1'b0;
            key_out_reg   <= '0;
            value_out_reg <= '0;
            enm_out_reg   <= '0;
            entry_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            pos_reg       <= pos_next;
            val_reg       <= val_next;
            enm_reg       <= enm_next;
            count_reg     <= count_next;
            wvalid_reg    <= wvalid_next;
            summ_reg      <= summ_next;
            done_reg      <= done_next;
            found_reg     <= found_next;
            key_out_reg   <= key_out_next;
            value_out_reg <= value_out_next;
            enm_out_reg   <= enm_out_next;
            entry_reg     <= entry_next;
        end
    end

    assign busy           = (state_reg != S_IDLE);
    assign done           = done_reg;
    assign found          = found_reg;
    assign key_out        = key_out_reg;
    assign value_out      = value_out_reg;
    assign enumerated_out = enm_out_reg;
    assign entry_count    = entry_reg;

    // a result only follows work in progress
    a_done_after_work: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg) != S_IDLE)
        else $error("result strobe without an item in progress");

    // an accepted item always leaves idle
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not start the sequencer");

    // the count never exceeds the key range
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= dkm_pkg::COUNT_W'(KEYS))
        else $error("present key count out of range");

    // a summary bit is only set on a word written since the last clear
    a_summary_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (summ_reg & ~wvalid_reg) == '0)
        else $error("summary bit set on an unwritten word");

    // an empty map has no summary bits
    a_empty_summary: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (summ_reg == '0))
        else $error("summary bits set on an empty map");

endmodule

/* test/testbench.sv */
// testbench for the dense key map: shadow map prediction, per-field result checks
module testbench;

    timeunit 1ns;
    timeprecision 1ps;

    // spare operation codes, the block must leave its state alone on these
    localparam logic [dkm_pkg::OP_W-1:0] OP_SPARE_LO = 3'd6;
    localparam logic [dkm_pkg::OP_W-1:0] OP_SPARE_HI = 3'd7;

    localparam int RANDOM_ITEMS = 600;
    localparam int DRAIN_CYCLES = 20;
    localparam int CYCLE_LIMIT = 200000;
    localparam int PRINT_LIMIT = 100;

    // one operation as the sender will present it
    typedef struct {
        logic [dkm_pkg::OP_W-1:0]    op;
        logic [dkm_pkg::KEY_W-1:0]   key;
        logic [dkm_pkg::VALUE_W-1:0] value;
        logic [dkm_pkg::ENUM_W-1:0]  enm;
        int                          gap_after;
        bit                          drain;
    } map_item_t;

    // one result as the block should report it
    typedef struct {
        logic                        found;
        logic [dkm_pkg::KEY_W-1:0]   key_out;
        logic [dkm_pkg::VALUE_W-1:0] value_out;
        logic [dkm_pkg::ENUM_W-1:0]  enum_out;
        logic [dkm_pkg::COUNT_W-1:0] count;
    } map_result_t;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         start = 1'b0;
    logic [dkm_pkg::OP_W-1:0]     operation = '0;
    logic [dkm_pkg::KEY_W-1:0]    key = '0;
    logic [dkm_pkg::VALUE_W-1:0]  value = '0;
    logic [dkm_pkg::ENUM_W-1:0]   enumerated = '0;
    logic                         busy;
    logic                         done;
    logic                         found;
    logic [dkm_pkg::KEY_W-1:0]    key_out;
    logic [dkm_pkg::VALUE_W-1:0]  value_out;
    logic [dkm_pkg::ENUM_W-1:0]   enumerated_out;
    logic [dkm_pkg::COUNT_W-1:0]  entry_count;

    // items waiting for the driver, and results waiting for the block
    map_item_t   item_queue[$];
    map_result_t pending_results[$];

    // shadow of the map as the block should hold it
    logic [dkm_pkg::KEY_SPACE-1:0] map_present = '0;
    logic [dkm_pkg::VALUE_W-1:0]   map_values [dkm_pkg::KEY_SPACE];
    int                            map_count = 0;

    // presence as the item generator plans it, used to build enumeration walks
    logic [dkm_pkg::KEY_SPACE-1:0] plan_present = '0;
    int                            plan_count = 0;
    int                            gap_limit = 6;

    logic accepted = 1'b0;
    int   accepted_total = 0;
    int   item_total = 0;
    int   result_index = 0;
    int   error_count = 0;
    int   cycle_count = 0;
    int   gap_left = 0;
    int   cur_gap = 0;

    dense_key_map_with_presence_bitmap dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .operation      (operation),
        .key            (key),
        .value          (value),
        .enumerated     (enumerated),
        .done           (done),
        .found          (found),
        .key_out        (key_out),
        .value_out      (value_out),
        .enumerated_out (enumerated_out),
        .entry_count    (entry_count)
    );

    always #1 clk = ~clk;

    // lowest set position at or above from, KEY_SPACE when there is none
    function automatic int lowest_from(logic [dkm_pkg::KEY_SPACE-1:0] bits, int from);
        for (int k = from; k < dkm_pkg::KEY_SPACE; k++)
        begin
            if (bits[k])
            begin
                return k;
            end
        end
        return dkm_pkg::KEY_SPACE;
    endfunction

    // applies one operation to the shadow map and returns what the block must report
    function automatic map_result_t apply_map_op(logic [dkm_pkg::OP_W-1:0] op,
                                                 logic [dkm_pkg::KEY_W-1:0] k,
                                                 logic [dkm_pkg::VALUE_W-1:0] v,
                                                 logic [dkm_pkg::ENUM_W-1:0] enm);
        map_result_t r;
        int          hit;
        r = '{default: '0};
        case (op)
            dkm_pkg::OP_SET:
            begin
                map_values[k] = v;
                if (!map_present[k])
                begin
                    map_present[k] = 1'b1;
                    map_count++;
                end
            end
            dkm_pkg::OP_ERASE:
            begin
                if (map_present[k])
                begin
                    map_present[k] = 1'b0;
                    map_count--;
                end
            end
            dkm_pkg::OP_LOOKUP:
            begin
                if (map_present[k])
                begin
                    r.found = 1'b1;
                    r.value_out = map_values[k];
                end
            end
            dkm_pkg::OP_FIND_FIRST:
            begin
                hit = lowest_from(map_present, 0);
                if (hit < dkm_pkg::KEY_SPACE)
                begin
                    r.found = 1'b1;
                    r.key_out = hit[dkm_pkg::KEY_W-1:0];
                    r.value_out = map_values[hit];
                end
            end
            dkm_pkg::OP_FIND_NEXT:
            begin
                // the walk stops once the caller has seen as many keys as are present
                if (int'(enm) < map_count)
                begin
                    hit = lowest_from(map_present, int'(k) + 1);
                    if (hit < dkm_pkg::KEY_SPACE)
                    begin
                        r.found = 1'b1;
                        r.key_out = hit[dkm_pkg::KEY_W-1:0];
                        r.value_out = map_values[hit];
                    end
                end
                // enumeration count saturates at the top of its field
                r.enum_out = (&enm) ? enm : enm + 1'b1;
            end
            dkm_pkg::OP_CLEAR:
            begin
                map_present = '0;
                map_count = 0;
            end
            default:
            begin
            end
        endcase
        r.count = map_count[dkm_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // queues one item with a drawn gap and keeps the planned presence in step
    function automatic void queue_item(logic [dkm_pkg::OP_W-1:0] op,
                                       logic [dkm_pkg::KEY_W-1:0] k,
                                       logic [dkm_pkg::VALUE_W-1:0] v,
                                       logic [dkm_pkg::ENUM_W-1:0] enm,
                                       bit drain);
        map_item_t it;
        it.op = op;
        it.key = k;
        it.value = v;
        it.enm = enm;
        it.gap_after = $urandom_range(0, gap_limit);
        it.drain = drain;
        item_queue.push_back(it);
        case (op)
            dkm_pkg::OP_SET:
            begin
                if (!plan_present[k])
                begin
                    plan_count++;
                end
                plan_present[k] = 1'b1;
            end
            dkm_pkg::OP_ERASE:
            begin
                if (plan_present[k])
                begin
                    plan_count--;
                end
                plan_present[k] = 1'b0;
            end
            dkm_pkg::OP_CLEAR:
            begin
                plan_present = '0;
                plan_count = 0;
            end
            default:
            begin
            end
        endcase
    endfunction

    // mostly a small window of keys so that sets, erases and lookups meet,
    // with the range ends and the whole range mixed in
    function automatic logic [dkm_pkg::KEY_W-1:0] pick_key();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
        begin
            return dkm_pkg::KEY_W'($urandom_range(0, 63));
        end
        if (r == 7)
        begin
            return $urandom_range(0, 1)
                ? dkm_pkg::KEY_W'(dkm_pkg::KEY_SPACE - 1 - $urandom_range(0, 1))
                : dkm_pkg::KEY_W'($urandom_range(0, 1));
        end
        return dkm_pkg::KEY_W'($urandom_range(0, dkm_pkg::KEY_SPACE - 1));
    endfunction

    function automatic logic [dkm_pkg::VALUE_W-1:0] random_value();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [dkm_pkg::ENUM_W-1:0] random_enum();
        return dkm_pkg::ENUM_W'($urandom_range(0, (1 << dkm_pkg::ENUM_W) - 1));
    endfunction

    task automatic report_mismatch(string field, logic [dkm_pkg::VALUE_W-1:0] got,
                                   logic [dkm_pkg::VALUE_W-1:0] want);
        // keep the log short when the block is badly broken, but count every miss
        if (error_count < PRINT_LIMIT)
        begin
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     result_index, field, got, want);
        end
        error_count++;
    endtask

    // driver: new item fields and start change at the falling edge; an item
    // stays on the ports until the rising edge that finds busy low takes it
    always @(negedge clk)
    begin : driver
        map_item_t head;
        logic      launch;
        launch = 1'b0;
        if (rst_n && !(start && !accepted))
        begin
            // the item on the ports was just taken: its gap starts now
            if (start)
            begin
                gap_left = cur_gap;
            end
            if (gap_left > 0)
            begin
                gap_left--;
            end
            else if (item_queue.size() > 0
                     && !(item_queue[0].drain && pending_results.size() > 0))
            begin
                // a drain item holds back until every outstanding result is in
                head = item_queue.pop_front();
                operation <= head.op;
                key <= head.key;
                value <= head.value;
                enumerated <= head.enm;
                cur_gap = head.gap_after;
                launch = 1'b1;
            end
            start <= launch;
        end
    end

    // monitor: checks the result first, then predicts for a newly taken item,
    // so a result and a new item on the same edge never get mixed up
    always @(posedge clk)
    begin : monitor
        map_result_t want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", CYCLE_LIMIT);
            $display("dense_key_map_with_presence_bitmap test failed");
            $finish;
        end
        else if (rst_n)
        begin
            if (done)
            begin
                if (pending_results.size() == 0)
                begin
                    report_mismatch("result with no item pending",
                                    dkm_pkg::VALUE_W'(entry_count), '0);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (found !== want.found)
                    begin
                        report_mismatch("found", dkm_pkg::VALUE_W'(found),
                                        dkm_pkg::VALUE_W'(want.found));
                    end
                    if (key_out !== want.key_out)
                    begin
                        report_mismatch("key_out", dkm_pkg::VALUE_W'(key_out),
                                        dkm_pkg::VALUE_W'(want.key_out));
                    end
                    if (value_out !== want.value_out)
                    begin
                        report_mismatch("value_out", value_out, want.value_out);
                    end
                    if (enumerated_out !== want.enum_out)
                    begin
                        report_mismatch("enumerated_out", dkm_pkg::VALUE_W'(enumerated_out),
                                        dkm_pkg::VALUE_W'(want.enum_out));
                    end
                    if (entry_count !== want.count)
                    begin
                        report_mismatch("entry_count", dkm_pkg::VALUE_W'(entry_count),
                                        dkm_pkg::VALUE_W'(want.count));
                    end
                end
                result_index++;
            end
            accepted <= start && !busy;
            if (start && !busy)
            begin
                pending_results.push_back(apply_map_op(operation, key, value, enumerated));
                accepted_total++;
            end
        end
    end

    initial
    begin : stimulus
        int made;
        int pick;
        int cur;
        int steps;
        int idx;
        logic [dkm_pkg::ENUM_W-1:0] enm;

        // empty map: lookup, find first and find next all miss
        queue_item(dkm_pkg::OP_LOOKUP, 10'd5, '0, '0, 1'b0);
        queue_item(dkm_pkg::OP_FIND_FIRST, '0, '0, '0, 1'b0);
        queue_item(dkm_pkg::OP_FIND_NEXT, '0, '0, '0, 1'b0);
        // range ends, value extremes, overwrite of a present key
        queue_item(dkm_pkg::OP_SET, '0, '1, '0, 1'b0);
        queue_item(dkm_pkg::OP_SET, '1, '0, '0, 1'b0);
        queue_item(dkm_pkg::OP_SET, 10'd512, 64'ha5a5_5a5a_f0f0_0f0f, '0, 1'b0);
        queue_item(dkm_pkg::OP_SET, '0, 64'h0123_4567_89ab_cdef, '0, 1'b0);
        queue_item(dkm_pkg::OP_LOOKUP, '0, '0, '0, 1'b0);
        queue_item(dkm_pkg::OP_LOOKUP, '1, '0, '0, 1'b0);
        queue_item(dkm_pkg::OP_LOOKUP, 10'd1, '0, '0, 1'b0);
        // full walk, walk off the top, walk cut short by the count, saturation
        queue_item(dkm_pkg::OP_FIND_FIRST, '1, '1, '1, 1'b0);
        queue_item(dkm_pkg::OP_FIND_NEXT, '0, '0, 11'd0, 1'b0);
        queue_item(dkm_pkg::OP_FIND_NEXT, 10'd512, '0, 11'd1, 1'b0);
        queue_item(dkm_pkg::OP_FIND_NEXT, '1, '0, 11'd2, 1'b0);
        queue_item(dkm_pkg::OP_FIND_NEXT, '0, '0, 11'd3, 1'b0);
        queue_item(dkm_pkg::OP_FIND_NEXT, '0, '1, '1, 1'b0);
        queue_item(dkm_pkg::OP_FIND_NEXT, 10'd1022, '0, 11'd0, 1'b0);
        // erase of an absent key, erase of the lowest key
        queue_item(dkm_pkg::OP_ERASE, 10'd1, '0, '0, 1'b0);
        queue_item(dkm_pkg::OP_ERASE, '0, '0, '0, 1'b0);
        queue_item(dkm_pkg::OP_FIND_FIRST, '0, '0, '0, 1'b0);
        // spare codes must change nothing
        queue_item(OP_SPARE_LO, 10'd512, '1, '1, 1'b0);
        queue_item(OP_SPARE_HI, '1, '1, '1, 1'b0);
        // clear after a full drain, then nothing left to find
        queue_item(dkm_pkg::OP_CLEAR, '0, '0, '0, 1'b1);
        queue_item(dkm_pkg::OP_LOOKUP, 10'd512, '0, '0, 1'b0);
        queue_item(dkm_pkg::OP_FIND_FIRST, '0, '0, '0, 1'b0);

        made = 0;
        while (made < RANDOM_ITEMS)
        begin
            // switch between stretches with no idling and stretches with gaps
            if (made % 50 == 0)
            begin
                gap_limit = ($urandom_range(0, 2) == 0) ? 0 : 6;
            end
            pick = $urandom_range(0, 99);
            if (pick < 2)
            begin
                queue_item(dkm_pkg::OP_CLEAR, pick_key(), random_value(), random_enum(), 1'b0);
                made++;
            end
            else if (pick < 5)
            begin
                // noise: any code, any field values
                queue_item(dkm_pkg::OP_W'($urandom_range(0, (1 << dkm_pkg::OP_W) - 1)),
                           dkm_pkg::KEY_W'($urandom_range(0, dkm_pkg::KEY_SPACE - 1)),
                           random_value(), random_enum(), 1'b0);
                made++;
            end
            else if (pick < 35)
            begin
                queue_item(dkm_pkg::OP_SET, pick_key(), random_value(), random_enum(),
                           made % 150 == 75);
                made++;
            end
            else if (pick < 47)
            begin
                queue_item(dkm_pkg::OP_ERASE, pick_key(), random_value(), random_enum(), 1'b0);
                made++;
            end
            else if (pick < 66)
            begin
                queue_item(dkm_pkg::OP_LOOKUP, pick_key(), random_value(), random_enum(),
                           1'b0);
                made++;
            end
            else if (pick < 90)
            begin
                // enumeration walk from the lowest key, following the planned map,
                // sometimes with a stray count or cut off early
                queue_item(dkm_pkg::OP_FIND_FIRST, pick_key(), random_value(), random_enum(),
                           1'b0);
                made++;
                cur = lowest_from(plan_present, 0);
                steps = $urandom_range(1, 40);
                idx = 0;
                while (cur < dkm_pkg::KEY_SPACE && steps > 0)
                begin
                    enm = ($urandom_range(0, 9) == 0) ? random_enum()
                                                      : dkm_pkg::ENUM_W'(idx);
                    queue_item(dkm_pkg::OP_FIND_NEXT, dkm_pkg::KEY_W'(cur), random_value(),
                               enm, 1'b0);
                    made++;
                    idx++;
                    steps--;
                    cur = lowest_from(plan_present, cur + 1);
                end
            end
            else
            begin
                queue_item(dkm_pkg::OP_FIND_NEXT, pick_key(), random_value(),
                           $urandom_range(0, 1) ? random_enum()
                                                : dkm_pkg::ENUM_W'($urandom_range(0, plan_count)),
                           1'b0);
                made++;
            end
        end
        item_total = item_queue.size();

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (accepted_total < item_total || pending_results.size() > 0)
        begin
            @(posedge clk);
        end
        // watch for stray results after the last expected one
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
        begin
            $display("dense_key_map_with_presence_bitmap test passed");
        end
        else
        begin
            $display("dense_key_map_with_presence_bitmap test failed");
        end
        $finish;
    end

endmodule

/* dense_key_map_with_presence_bitmap.f */
rtl/core/dkm_pkg.sv
rtl/core/dkm_pri_enc.sv
rtl/core/dkm_mem.sv
rtl/core/dense_key_map_with_presence_bitmap.sv
test/testbench.sv
